@@ design/periodic_timer_scheduler_defines.svh @@
// ----------------------------------------------------------------------------
// Periodic timer scheduler assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_SCHEDULER_DEFINES_SVH
`define PERIODIC_TIMER_SCHEDULER_DEFINES_SVH

// implication checked every cycle outside reset
`define PTS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define PTS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

@@ design/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic timer scheduler package
// Transaction types, codes and shared constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pts_pkg;
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_ZERO      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] timer_id;
    logic [63:0] interval;
    logic [63:0] now;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_id;
    logic        fired;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [63:0] due;
    logic [63:0] period;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DEL, S_FIRE, S_DONE
  } state_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction
endpackage

@@ design/periodic_timer_scheduler.sv @@
// ----------------------------------------------------------------------------
// Periodic timer scheduler
// Table of periodic timers in one RAM; add, delete and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a clock edge with start high and busy
//   low. Results appear on rsp for one cycle each, marked by done; the last
//   result of a command has rsp.last set. The receiver cannot stall.
//   Add and unknown commands: an add with a nonzero interval and a free slot
//   writes the table at the accepting edge, and the single result follows in
//   the next cycle. Delete: a scan of the table RAM, one slot a cycle, then
//   the single result.
//   Tick: each fired timer costs one scan plus a write-back, plus one final
//   scan that finds nothing due. Each fired id is held until the next scan
//   ends, so the final one can carry last. The table RAM has one read port,
//   so every scan reads one slot at a time. Valid bits live in flip-flops.
//   Busy drops in the cycle after the last result; the next command can be
//   taken there. Reset clears all valid bits and sets the next id to one;
//   the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module periodic_timer_scheduler #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pts_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output pts_pkg::rsp_t rsp
);
  import pts_pkg::*;

  localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int NW = $clog2(TIMER_SLOTS + 2);

  state_t state, state_next;
  cmd_t   op;
  logic [TIMER_SLOTS-1:0] valid;
  logic [31:0] next_id;
  logic [CW-1:0] idx;
  logic          rd_pend;
  logic [AW-1:0] rd_slot;
  logic          best_ok;
  logic [AW-1:0] best_slot;
  entry_t        best;
  logic          found;
  logic [NW-1:0] nfired;
  logic [31:0]   last_id;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  pts_ram #(.WIDTH($bits(entry_t)), .DEPTH(TIMER_SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic scan_end;
  logic hit_due, better;
  logic hit_del;
  assign scan_end = (idx == CW'(TIMER_SLOTS)) && !rd_pend;
  assign ram_raddr = idx[AW-1:0];
  assign hit_due = rd_pend && valid[rd_slot] && (ram_rdata.due < op.now);
  assign better = !best_ok || (ram_rdata.due < best.due) ||
                  ((ram_rdata.due == best.due) && (ram_rdata.id < best.id));
  assign hit_del = rd_pend && valid[rd_slot] && (ram_rdata.id == op.timer_id);

  logic free_any;
  logic [AW-1:0] free_slot;
  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_any  = 1'b1;
        free_slot = AW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) begin
        if (cmd.opcode == OP_TICK) state_next = S_SCAN;
        else if (cmd.opcode == OP_DELETE) state_next = S_DEL;
        else state_next = S_DONE;
      end
      S_SCAN: if (scan_end) state_next = (best_ok && (nfired < NW'(TIMER_SLOTS)))
                                          ? S_FIRE : S_DONE;
      S_DEL:  if (scan_end) state_next = S_DONE;
      S_FIRE: state_next = S_SCAN;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_slot;
    ram_wdata = best;
    done      = 1'b0;
    rsp       = '0;
    busy      = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        ram_waddr = free_slot;
        ram_wdata = '{id: next_id, due: sat_add(cmd.now, cmd.interval),
                      period: cmd.interval};
        ram_we    = start && (cmd.opcode == OP_ADD) && (cmd.interval != '0) && free_any;
      end
      S_FIRE: begin
        ram_we        = 1'b1;
        ram_wdata.due = sat_add(op.now, best.period);
        done          = (nfired != '0);
        rsp           = '{status: ST_OK, result_id: last_id, fired: 1'b1, last: 1'b0};
      end
      S_DONE: begin
        done     = 1'b1;
        rsp.last = 1'b1;
        case (op.opcode)
          OP_ADD: begin
            if (op.interval == '0) rsp.status = ST_ZERO;
            else if (!found) rsp.status = ST_FULL;
            else rsp.result_id = op.timer_id;
          end
          OP_DELETE: rsp.status = found ? ST_OK : ST_NOT_FOUND;
          OP_TICK: if (nfired != '0) begin
            rsp = '{status: ST_OK, result_id: last_id, fired: 1'b1, last: 1'b1};
          end
          default: rsp.status = ST_OK;
        endcase
      end
      default: ;
    endcase
  end

  // Hold each fired id until the next scan ends; FIRE emits the held one,
  // DONE emits the newest with last set.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid   <= '0;
      next_id <= 32'd1;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start && cmd.opcode == OP_ADD &&
          cmd.interval != '0 && free_any) begin
        valid[free_slot] <= 1'b1;
        next_id <= next_id + 32'd1;
      end
      if (state == S_DEL && hit_del) begin
        valid[rd_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      idx     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          idx     <= '0;
        end
        S_SCAN, S_DEL: begin
          rd_pend <= (idx != CW'(TIMER_SLOTS));
          if (idx != CW'(TIMER_SLOTS)) idx <= idx + CW'(1);
        end
        default: begin
          rd_pend <= 1'b0;
          idx     <= '0;
        end
      endcase
    end
    rd_slot <= idx[AW-1:0];
    case (state)
      S_IDLE: begin
        op.opcode   <= cmd.opcode;
        op.interval <= cmd.interval;
        op.now      <= cmd.now;
        op.timer_id <= (cmd.opcode == OP_ADD) ? next_id : cmd.timer_id;
        best_ok     <= 1'b0;
        found       <= (cmd.opcode == OP_ADD) && free_any;
        nfired      <= '0;
      end
      S_SCAN: if (hit_due && better) begin
        best_ok   <= 1'b1;
        best      <= ram_rdata;
        best_slot <= rd_slot;
      end
      S_DEL: if (hit_del) found <= 1'b1;
      S_FIRE: begin
        best_ok <= 1'b0;
        nfired  <= nfired + NW'(1);
        last_id <= best.id;
      end
      default: ;
    endcase
  end
endmodule

@@ design/pts_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/pts_checker.sv @@
// ----------------------------------------------------------------------------
// Periodic timer scheduler checker
// Port-level properties of the command and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_timer_scheduler_defines.svh"
module pts_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input pts_pkg::rsp_t rsp
);
  import pts_pkg::*;

  `PTS_ASSERT_NEXT(a_take_busy, clk, rst, start && !busy, busy)
  `PTS_ASSERT_IMP(a_done_busy, clk, rst, done, busy)
  `PTS_ASSERT_NEXT(a_last_idle, clk, rst, done && rsp.last, !busy)
  `PTS_ASSERT_IMP(a_fired_ok, clk, rst, done && rsp.fired, rsp.status == ST_OK)
endmodule

bind periodic_timer_scheduler pts_checker u_pts_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
